// File: src/websocket_frame_unmasker_assert.svh
// ----------------------------------------------------------------------------
// WebSocket frame unmasker assertion macros
// Shared concurrent assertion forms used by the wfu_parse module.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WFU_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("websocket_frame_unmasker: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define WFU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("websocket_frame_unmasker: next-cycle check failed");

`endif

// File: src/wfu_pkg.sv
// ----------------------------------------------------------------------------
// wfu_pkg
// Types and constants shared by the WebSocket frame unmasker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfu_pkg;

   // Result status codes
   localparam logic [2:0] ST_DATA    = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_CODE127 = 3'd2;
   localparam logic [2:0] ST_TOOLONG = 3'd3;
   localparam logic [2:0] ST_TRUNC   = 3'd4;

   // Length codes in the second header byte
   localparam logic [6:0] LEN_EXT16  = 7'd126;
   localparam logic [6:0] LEN_EXT64  = 7'd127;

   // Register map
   localparam int         ADDR_W            = 2;
   localparam logic [1:0] ADDR_MAX_PAYLOAD  = 2'd0;
   localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1023;

   // Input word
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       first_in_buffer;
      logic       last_in_buffer;
   } req_type;

   // Result word
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  data;
      logic        last_of_frame;
      logic [15:0] payload_size;
   } rsp_type;

   // Step control from the input stage to the parser
   typedef struct packed {
      logic item_valid;   // input register holds a word
      logic advance;      // result register can take a new value
   } ctl_type;

endpackage

// File: src/websocket_frame_unmasker.sv
// Path: a word's result, if any, passes from the input register to the result
// register and is offered from there; a stalled result can hold both registers.
// Throughput: one word per cycle while the result side is ready; when a
// result is stalled, one more word can still wait in the input register.
// Reset: synchronous active high; parser returns to the first header byte,
// max_payload returns to 1023, both registers empty.
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Byte-wide WebSocket frame deframer that strips the header and unmasks data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_unmasker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  wfu_pkg::req_type           req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output wfu_pkg::rsp_type           rsp_word,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [wfu_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic             in_valid_ff, in_valid_in;
   wfu_pkg::req_type in_word_ff,  in_word_in;
   logic [15:0]      max_payload;
   wfu_pkg::ctl_type ctl;

   assign ctl.item_valid = in_valid_ff;
   assign ctl.advance    = !rsp_valid || rsp_ready;
   assign req_ready      = !in_valid_ff || ctl.advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_word_ff <= in_word_in;
   end

   wfu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .max_payload (max_payload)
   );

   wfu_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .in_word     (in_word_ff),
      .max_payload (max_payload),
      .out_valid   (rsp_valid),
      .out_word    (rsp_word)
   );

endmodule

// File: src/wfu_csr.sv
// ----------------------------------------------------------------------------
// wfu_csr
// APB-style register port holding the max_payload limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfu_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [wfu_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic [15:0]                max_payload
);

   logic [15:0] max_payload_ff;
   logic [15:0] max_payload_in;
   logic        wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == wfu_pkg::ADDR_MAX_PAYLOAD);

   // register write
   always_comb begin
      max_payload_in = max_payload_ff;
      if (wr_hit) begin
         max_payload_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= wfu_pkg::MAX_PAYLOAD_RST;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   // read back
   assign prdata      = (paddr == wfu_pkg::ADDR_MAX_PAYLOAD) ? {16'd0, max_payload_ff} : 32'd0;
   assign max_payload = max_payload_ff;

endmodule

// File: src/wfu_parse.sv
// ----------------------------------------------------------------------------
// wfu_parse
// Frame header parser, key capture and payload unmask with result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "websocket_frame_unmasker_assert.svh"

module wfu_parse (
   input  logic             clock,
   input  logic             reset,
   input  wfu_pkg::ctl_type ctl,
   input  wfu_pkg::req_type in_word,
   input  logic [15:0]      max_payload,
   output logic             out_valid,
   output wfu_pkg::rsp_type out_word
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT0,
      PH_EXT1,
      PH_KEY,
      PH_DATA,
      PH_DONE
   } phase_type;

   phase_type        phase_ff,       phase_in;
   logic [15:0]      payload_len_ff, payload_len_in;
   logic [15:0]      byte_count_ff,  byte_count_in;
   logic [3:0][7:0]  mask_key_ff,    mask_key_in;
   logic [1:0]       key_index_ff,   key_index_in;
   logic             out_valid_ff,   out_valid_in;
   wfu_pkg::rsp_type out_word_ff,    out_word_in;

   phase_type        ph;
   logic [15:0]      plen;
   logic [15:0]      bcnt;
   logic [3:0][7:0]  key;
   logic [1:0]       kidx;
   logic [15:0]      bcnt_inc;
   logic [7:0]       unmasked;
   logic             too_long;
   logic             res_valid;
   wfu_pkg::rsp_type res;
   logic             fire;

   assign fire = ctl.item_valid && ctl.advance;

   // next state and result for the word in the input register
   always_comb begin
      ph   = phase_ff;
      plen = payload_len_ff;
      bcnt = byte_count_ff;
      key  = mask_key_ff;
      kidx = key_index_ff;
      if (in_word.first_in_buffer) begin
         ph   = PH_HDR0;
         plen = '0;
         bcnt = '0;
         key  = '0;
         kidx = '0;
      end

      phase_in       = ph;
      payload_len_in = plen;
      byte_count_in  = bcnt;
      mask_key_in    = key;
      key_index_in   = kidx;

      bcnt_inc  = bcnt + 16'd1;
      unmasked  = in_word.rx_byte ^ key[bcnt[1:0]];
      too_long  = plen > max_payload;
      res_valid = 1'b0;
      res       = '0;

      case (ph)
         PH_HDR0: begin
            if (in_word.last_in_buffer) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.status        = wfu_pkg::ST_TRUNC;
               res.last_of_frame = 1'b1;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            if (in_word.rx_byte[6:0] == wfu_pkg::LEN_EXT64) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.status        = wfu_pkg::ST_CODE127;
               res.last_of_frame = 1'b1;
            end else begin
               if (in_word.rx_byte[6:0] != wfu_pkg::LEN_EXT16) begin
                  payload_len_in = {9'd0, in_word.rx_byte[6:0]};
               end
               if (in_word.last_in_buffer) begin
                  phase_in  = PH_DONE;
                  res_valid = 1'b1;
                  res.status        = wfu_pkg::ST_TRUNC;
                  res.last_of_frame = 1'b1;
               end else if (in_word.rx_byte[6:0] == wfu_pkg::LEN_EXT16) begin
                  phase_in = PH_EXT0;
               end else begin
                  key_index_in = '0;
                  phase_in     = PH_KEY;
               end
            end
         end
         PH_EXT0, PH_EXT1: begin
            // extended length, high byte first, unsigned
            if (ph == PH_EXT0) begin
               payload_len_in = {in_word.rx_byte, 8'd0};
            end else begin
               payload_len_in = {plen[15:8], in_word.rx_byte};
            end
            if (in_word.last_in_buffer) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.status        = wfu_pkg::ST_TRUNC;
               res.last_of_frame = 1'b1;
            end else if (ph == PH_EXT0) begin
               phase_in = PH_EXT1;
            end else begin
               key_index_in = '0;
               phase_in     = PH_KEY;
            end
         end
         PH_KEY: begin
            mask_key_in[kidx] = in_word.rx_byte;
            if (kidx == 2'd3) begin
               key_index_in = '0;
               if (plen == 16'd0) begin
                  // empty frame ends on the last key byte
                  phase_in  = PH_DONE;
                  res_valid = 1'b1;
                  res.status        = wfu_pkg::ST_EMPTY;
                  res.last_of_frame = 1'b1;
               end else if (in_word.last_in_buffer) begin
                  phase_in  = PH_DONE;
                  res_valid = 1'b1;
                  res.status        = wfu_pkg::ST_TRUNC;
                  res.last_of_frame = 1'b1;
               end else begin
                  byte_count_in = '0;
                  phase_in      = PH_DATA;
               end
            end else if (in_word.last_in_buffer) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.status        = wfu_pkg::ST_TRUNC;
               res.last_of_frame = 1'b1;
            end else begin
               key_index_in = kidx + 2'd1;
            end
         end
         PH_DATA: begin
            byte_count_in = bcnt_inc;
            if (bcnt_inc == plen) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.status        = too_long ? wfu_pkg::ST_TOOLONG : wfu_pkg::ST_DATA;
               res.data          = too_long ? 8'd0 : unmasked;
               res.last_of_frame = 1'b1;
               res.payload_size  = plen;
            end else if (in_word.last_in_buffer) begin
               phase_in  = PH_DONE;
               res_valid = 1'b1;
               res.status        = wfu_pkg::ST_TRUNC;
               res.last_of_frame = 1'b1;
            end else if (!too_long) begin
               res_valid = 1'b1;
               res.status = wfu_pkg::ST_DATA;
               res.data   = unmasked;
            end
         end
         default: begin
            // after the frame: ignore until the next buffer
         end
      endcase
   end

   // result register loads whenever it is free or being drained
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (ctl.advance) begin
         out_valid_in = fire && res_valid;
         out_word_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR0;
         payload_len_ff <= '0;
         byte_count_ff  <= '0;
         mask_key_ff    <= '0;
         key_index_ff   <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff       <= phase_in;
            payload_len_ff <= payload_len_in;
            byte_count_ff  <= byte_count_in;
            mask_key_ff    <= mask_key_in;
            key_index_ff   <= key_index_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_word_ff <= out_word_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   // checks
   `WFU_ASSERT_IMPLY(a_err_is_last, clock, reset,
      out_valid_ff && (out_word_ff.status != wfu_pkg::ST_DATA), out_word_ff.last_of_frame)
   `WFU_ASSERT_IMPLY(a_len_only_on_last, clock, reset,
      out_valid_ff && !out_word_ff.last_of_frame, out_word_ff.payload_size == 16'd0)
   `WFU_ASSERT_NEXT(a_last_ends_frame, clock, reset,
      fire && res_valid && res.last_of_frame, phase_ff == PH_DONE)
   `WFU_ASSERT_NEXT(a_hold_when_stalled, clock, reset,
      out_valid_ff && !ctl.advance, out_valid_ff && $stable(out_word_ff))

endmodule

// File: test/websocket_frame_unmasker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_tb
// Streams received buffers, well-formed frames and broken ones, into the
// unmasker byte by byte. A scoreboard tracks the parser state and predicts
// every result word, and the actual words are checked in order.
// ----------------------------------------------------------------------------

module websocket_frame_unmasker_tb;

   localparam int WORDS_PER_STEP = 66;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;

   // Parser position, as tracked by the scoreboard
   typedef enum logic [2:0] {
      AT_HDR0, AT_HDR1, AT_EXT_HI, AT_EXT_LO, AT_KEY, AT_DATA, AT_DONE
   } parse_phase_type;

   // Directed words: {rx_byte, first_in_buffer, last_in_buffer}
   localparam logic [9:0] DIRECTED_WORDS [0:25] = '{
      {8'hA5, 1'b0, 1'b0},   // header byte without first flag after reset
      {8'h7F, 1'b0, 1'b0},   // 64-bit length code, rejected
      {8'h33, 1'b0, 1'b1},   // ignored after the frame
      {8'hFF, 1'b1, 1'b1},   // one-byte buffer, ends in the header
      {8'h81, 1'b1, 1'b0},   // empty frame closing on the buffer's last byte
      {8'h80, 1'b0, 1'b0},
      {8'h11, 1'b0, 1'b0},
      {8'h22, 1'b0, 1'b0},
      {8'h33, 1'b0, 1'b0},
      {8'h44, 1'b0, 1'b1},
      {8'h82, 1'b1, 1'b0},   // 16-bit length of 3, data at both extremes
      {8'hFE, 1'b0, 1'b0},
      {8'h00, 1'b0, 1'b0},
      {8'h03, 1'b0, 1'b0},
      {8'hFF, 1'b0, 1'b0},
      {8'h00, 1'b0, 1'b0},
      {8'hAA, 1'b0, 1'b0},
      {8'h55, 1'b0, 1'b0},
      {8'hFF, 1'b0, 1'b0},
      {8'h00, 1'b0, 1'b0},
      {8'h12, 1'b0, 1'b1},
      {8'h01, 1'b1, 1'b0},   // frame cut short by a new buffer
      {8'h05, 1'b0, 1'b0},
      {8'h00, 1'b0, 1'b0},
      {8'h02, 1'b1, 1'b0},   // buffer ends on the 16-bit length code
      {8'hFE, 1'b0, 1'b1}
   };

   // Scoreboard: tracks the parser and holds the results still due
   class unmask_scoreboard;
      logic [15:0]      max_payload = wfu_pkg::MAX_PAYLOAD_RST;
      parse_phase_type  phase       = AT_HDR0;
      logic [15:0]      payload_len = '0;
      logic [15:0]      byte_count  = '0;
      logic [31:0]      mask_key    = '0;
      logic [1:0]       key_index   = '0;
      wfu_pkg::rsp_type outcome;
      wfu_pkg::rsp_type due[$];
      int               mismatches;
      int               words_noted;
      int               results_checked;
      int               status_count[0:7];

      function bit emit(logic [2:0] st, logic [7:0] d, logic lastf, logic [15:0] len);
         outcome.status        = st;
         outcome.data          = d;
         outcome.last_of_frame = lastf;
         outcome.payload_size  = len;
         return 1'b1;
      endfunction

      function bit abort(logic [2:0] st);
         phase = AT_DONE;
         return emit(st, 8'h00, 1'b1, 16'd0);
      endfunction

      // Advance the parser by one byte; returns 1 when a result is due
      function bit unmask_byte(wfu_pkg::req_type w);
         logic [7:0] b;
         logic [7:0] clear;
         logic       over;
         b = w.rx_byte;
         if (w.first_in_buffer) begin
            phase       = AT_HDR0;
            payload_len = '0;
            byte_count  = '0;
            mask_key    = '0;
            key_index   = '0;
         end
         case (phase)
            AT_HDR0: begin
               if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
               phase = AT_HDR1;
            end
            AT_HDR1: begin
               if (b[6:0] == wfu_pkg::LEN_EXT64) return abort(wfu_pkg::ST_CODE127);
               if (b[6:0] == wfu_pkg::LEN_EXT16) begin
                  if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
                  phase = AT_EXT_HI;
               end else begin
                  payload_len = {9'd0, b[6:0]};
                  if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
                  key_index = '0;
                  phase     = AT_KEY;
               end
            end
            AT_EXT_HI: begin
               payload_len = {b, 8'h00};
               if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
               phase = AT_EXT_LO;
            end
            AT_EXT_LO: begin
               payload_len[7:0] = b;
               if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
               key_index = '0;
               phase     = AT_KEY;
            end
            AT_KEY: begin
               mask_key[8*key_index +: 8] = b;
               if (key_index == 2'd3) begin
                  key_index = '0;
                  if (payload_len == 16'd0) begin
                     phase = AT_DONE;
                     return emit(wfu_pkg::ST_EMPTY, 8'h00, 1'b1, 16'd0);
                  end
                  if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
                  byte_count = '0;
                  phase      = AT_DATA;
               end else begin
                  if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
                  key_index = key_index + 2'd1;
               end
            end
            AT_DATA: begin
               clear      = b ^ mask_key[8*byte_count[1:0] +: 8];
               over       = payload_len > max_payload;
               byte_count = byte_count + 16'd1;
               if (byte_count == payload_len) begin
                  phase = AT_DONE;
                  if (over) return emit(wfu_pkg::ST_TOOLONG, 8'h00, 1'b1, payload_len);
                  return emit(wfu_pkg::ST_DATA, clear, 1'b1, payload_len);
               end
               if (w.last_in_buffer) return abort(wfu_pkg::ST_TRUNC);
               if (!over) return emit(wfu_pkg::ST_DATA, clear, 1'b0, 16'd0);
            end
            default: ;
         endcase
         return 1'b0;
      endfunction

      function void note_word(wfu_pkg::req_type w);
         words_noted++;
         if (unmask_byte(w)) due.push_back(outcome);
      endfunction

      function void report(string field, logic [15:0] want_v, logic [15:0] got_v);
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
         mismatches++;
      endfunction

      function void check_result(wfu_pkg::rsp_type got);
         wfu_pkg::rsp_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got status %0h data %0h",
                     $time, got.status, got.data);
            mismatches++;
            return;
         end
         want = due.pop_front();
         results_checked++;
         status_count[want.status]++;
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.data !== want.data) report("data", want.data, got.data);
         if (got.last_of_frame !== want.last_of_frame)
            report("last_of_frame", want.last_of_frame, got.last_of_frame);
         if (got.payload_size !== want.payload_size)
            report("payload_size", want.payload_size, got.payload_size);
      endfunction
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   wfu_pkg::req_type           req_word  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   wfu_pkg::rsp_type           rsp_word;
   logic                       psel      = 1'b0;
   logic                       penable   = 1'b0;
   logic                       pwrite    = 1'b0;
   logic [wfu_pkg::ADDR_W-1:0] paddr     = '0;
   logic [31:0]                pwdata    = '0;
   logic [31:0]                prdata;
   logic                       pready;

   unmask_scoreboard    sb = new();
   bit                  req_burst;
   bit                  rsp_hold;
   int                  words_sent;
   int                  idle_cycles;

   websocket_frame_unmasker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (psel && penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Result side: random stalls, bursts with none, one long hold on request
   initial begin : rsp_side
      int stall;
      int burst_left;
      burst_left = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (rsp_hold) begin
            stall    = HOLD_CYCLES;
            rsp_hold = 1'b0;
         end else if (burst_left > 0) begin
            stall = 0;
            burst_left--;
         end else begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) burst_left = 24;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_word);
         @(negedge clock);
      end
   end

   // Offer one word, after a random gap unless in a burst, and wait until it is taken
   task automatic send_word(input wfu_pkg::req_type w);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_word(w);
      words_sent++;
   endtask

   task automatic send_buffer(input logic [7:0] bytes[$], input bit with_first,
                              input int last_at);
      wfu_pkg::req_type w;
      for (int i = 0; i < bytes.size(); i++) begin
         w.rx_byte         = bytes[i];
         w.first_in_buffer = with_first && (i == 0);
         w.last_in_buffer  = (i == last_at);
         send_word(w);
      end
   endtask

   // Header, length, key and masked payload of one frame
   function automatic void push_frame(ref logic [7:0] bytes[$], input int plen,
                                      input bit ext, input int data_n);
      logic [15:0] len16;
      len16 = 16'(plen);
      bytes.push_back(8'($urandom));
      if (ext) begin
         bytes.push_back({1'($urandom_range(0, 1)), wfu_pkg::LEN_EXT16});
         bytes.push_back(len16[15:8]);
         bytes.push_back(len16[7:0]);
      end else begin
         bytes.push_back({1'($urandom_range(0, 1)), len16[6:0]});
      end
      repeat (4 + data_n) bytes.push_back(8'($urandom));
   endfunction

   // Drop valid, let every due result out, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [15:0] value);
      logic [31:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= wfu_pkg::ADDR_MAX_PAYLOAD;
      pwdata  <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      if (wr) begin
         sb.max_payload = value;
      end else if (got[15:0] !== value) begin
         $display("%0t: max_payload readback mismatch, expected %0h, got %0h",
                  $time, value, got[15:0]);
         sb.mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // One random buffer: mostly good frames, some cut short, some with the 64-bit length code, some noise
   task automatic send_random_buffer();
      logic [7:0]       bytes[$];
      wfu_pkg::req_type w;
      int               pick;
      int               plen;
      int               data_n;
      int               last_at;
      bit               ext;
      bit               with_first;
      pick       = $urandom_range(0, 99);
      req_burst  = ($urandom_range(0, 5) == 0);
      with_first = ($urandom_range(0, 19) != 0);
      if (pick < 88) begin
         ext = ($urandom_range(0, 4) == 0);
         if (pick >= 65 && $urandom_range(0, 2) == 0) begin
            ext  = 1'b1;
            plen = $urandom_range(0, 65535);
         end else if (ext) begin
            plen = $urandom_range(0, 40);
         end else if ($urandom_range(0, 40) == 0) begin
            plen = 125;
         end else begin
            plen = $urandom_range(0, 12);
         end
         data_n = (plen > 40) ? $urandom_range(0, 40) : plen;
         push_frame(bytes, plen, ext, data_n);
         if (pick < 65) begin
            // complete frame, maybe with stray bytes behind it
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
            last_at = bytes.size() - 1;
         end else if (pick < 80) begin
            last_at = $urandom_range(0, bytes.size() - 1);
         end else begin
            // cut off with no last flag, the next buffer restarts
            data_n = $urandom_range(1, bytes.size());
            while (bytes.size() > data_n) void'(bytes.pop_back());
            last_at = -1;
         end
         send_buffer(bytes, with_first, last_at);
      end else if (pick < 94) begin
         bytes.push_back(8'($urandom));
         bytes.push_back({1'($urandom_range(0, 1)), wfu_pkg::LEN_EXT64});
         repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
         send_buffer(bytes, with_first, bytes.size() - 1);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            w.rx_byte         = 8'($urandom);
            w.first_in_buffer = ($urandom_range(0, 3) == 0);
            w.last_in_buffer  = ($urandom_range(0, 3) == 0);
            send_word(w);
         end
      end
   endtask

   initial begin : stimulus
      logic [15:0] limits[0:5];
      logic [7:0]  bytes[$];
      int          target;
      limits = '{16'd0, 16'd65535, 16'd4, 16'd9, 16'd125, wfu_pkg::MAX_PAYLOAD_RST};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset value, then the directed words
      csr_access(1'b0, wfu_pkg::MAX_PAYLOAD_RST);
      foreach (DIRECTED_WORDS[i]) send_word(wfu_pkg::req_type'(DIRECTED_WORDS[i]));

      // Random buffers, one stretch per max_payload setting
      target = words_sent;
      for (int p = 0; p < 6; p++) begin
         drain();
         csr_access(1'b1, limits[p]);
         csr_access(1'b0, limits[p]);
         if (p == 1) begin
            // long output hold while a frame streams in back to back
            rsp_hold  = 1'b1;
            req_burst = 1'b1;
            bytes.delete();
            push_frame(bytes, 24, 1'b0, 24);
            send_buffer(bytes, 1'b1, bytes.size() - 1);
         end
         target += WORDS_PER_STEP;
         while (words_sent < target) send_random_buffer();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.due.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.due.size());
         sb.mismatches += sb.due.size();
      end

      $display("Sent %0d input words over six max_payload settings; checked %0d results:",
               sb.words_noted, sb.results_checked);
      $display("  data %0d, empty %0d, code 127 %0d, too long %0d, truncated %0d",
               sb.status_count[wfu_pkg::ST_DATA], sb.status_count[wfu_pkg::ST_EMPTY],
               sb.status_count[wfu_pkg::ST_CODE127], sb.status_count[wfu_pkg::ST_TOOLONG],
               sb.status_count[wfu_pkg::ST_TRUNC]);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
